[hdl/cst_pkg.sv]
// Shared types, widths and constants for the congestion signal tracker.
// No dependencies.
package cst_pkg;

    localparam int TICK_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int GAP_W     = 30;
    localparam int LOSS_W    = 17;
    localparam int LINK_W    = 32;
    localparam int QUEUE_W   = 16;
    localparam int SEQ_W     = 32;
    localparam int CNT_W     = 6;

    localparam logic [GAP_W-1:0]  GAP_SAT   = GAP_W'(64'd16380 << FRAC_BITS);
    localparam logic [LOSS_W-1:0] ONE_LOSS  = LOSS_W'(64'd1 << FRAC_BITS);
    localparam logic [GAP_W-1:0]  ONE_RATIO = GAP_W'(64'd1 << FRAC_BITS);
    localparam logic [TICK_BITS-1:0] GAP_CLAMP = TICK_BITS'(64'd1 << 23);
    localparam logic [TICK_BITS-1:0] Q_LIMIT   = TICK_BITS'(16380);

    localparam logic [2:0] REG_SEND  = 3'd0;
    localparam logic [2:0] REG_RECV  = 3'd1;
    localparam logic [2:0] REG_SLOW  = 3'd2;
    localparam logic [2:0] REG_RATIO = 3'd3;
    localparam logic [2:0] REG_LOSS  = 3'd4;
    localparam logic [2:0] REG_LINK  = 3'd5;
    localparam logic [2:0] REG_QUEUE = 3'd6;

    typedef struct packed {
        logic [GAP_W-1:0]  send_gap;
        logic [GAP_W-1:0]  recv_gap;
        logic [GAP_W-1:0]  slow_gap;
        logic [GAP_W-1:0]  ratio;
        logic [LOSS_W-1:0] loss;
        logic [LINK_W-1:0] link;
        logic [QUEUE_W-1:0] queue;
    } init_t;

    localparam init_t INIT_RESET = init_t'({{(3*GAP_W){1'b0}}, ONE_RATIO,
                                            {(LOSS_W+LINK_W+QUEUE_W){1'b0}}});

    typedef struct packed {
        logic load;     // capture input word
        logic update;   // run EWMA / tick update
        logic div_start;
        logic div_step;
        logic finish;   // write ratio
    } cmd_t;

    typedef struct packed {
        logic restart;
        logic first;
        logic div_last;
    } status_t;

endpackage

[hdl/congestion_signal_tracker_top.sv]
// channel  | dir | signals                    | content
// s_axis   | in  | s_axis_tvalid/tready/tdata | packet record or restart
// m_axis   | out | m_axis_tvalid/tready/tdata | estimator state after the word
// apb      | in  | psel/penable/pwrite/paddr  | restart values, 7 registers
// A packet word passes through an update step, 48 steps of the restoring divider
// for the RTT ratio and a finish step before its result is valid.
// A restart or first-sample word skips the divider and goes from the update step to the output.
// The next word is taken the cycle after the result is taken.
// Reset is asynchronous, active low.
// Depends on cst_pkg, cst_ctrl, cst_datapath.
module congestion_signal_tracker_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tuser,  // action
    input  logic [127:0] s_axis_tdata,  // sent_tick, recv_tick, seq_number,
                                        // queue_sample, link_sample
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [223:0] m_axis_tdata,  // send_gap_avg, recv_gap_avg,
                                        // slow_recv_gap_avg, ratio_out, loss_avg,
                                        // queue_latest, link_avg, min_rtt_out
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cst_pkg::cmd_t    cmd;
    cst_pkg::status_t status;
    cst_pkg::init_t   init_reg;
    logic [2:0]       idx;
    logic             wr;

    logic [29:0] send_gap, recv_gap, slow_gap, ratio;
    logic [16:0] loss;
    logic [15:0] queue;
    logic [31:0] link, min_rtt;

    assign pready = 1'b1;
    assign idx = paddr[4:2];
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= cst_pkg::INIT_RESET;
        end
        else if (wr)
        begin
            case (idx)
                cst_pkg::REG_SEND:  init_reg.send_gap <= pwdata[29:0];
                cst_pkg::REG_RECV:  init_reg.recv_gap <= pwdata[29:0];
                cst_pkg::REG_SLOW:  init_reg.slow_gap <= pwdata[29:0];
                cst_pkg::REG_RATIO: init_reg.ratio    <= pwdata[29:0];
                cst_pkg::REG_LOSS:  init_reg.loss     <= pwdata[16:0];
                cst_pkg::REG_LINK:  init_reg.link     <= pwdata;
                cst_pkg::REG_QUEUE: init_reg.queue    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            cst_pkg::REG_SEND:  prdata = {2'b0, init_reg.send_gap};
            cst_pkg::REG_RECV:  prdata = {2'b0, init_reg.recv_gap};
            cst_pkg::REG_SLOW:  prdata = {2'b0, init_reg.slow_gap};
            cst_pkg::REG_RATIO: prdata = {2'b0, init_reg.ratio};
            cst_pkg::REG_LOSS:  prdata = {15'b0, init_reg.loss};
            cst_pkg::REG_LINK:  prdata = init_reg.link;
            cst_pkg::REG_QUEUE: prdata = {16'b0, init_reg.queue};
            default:            prdata = '0;
        endcase
    end

    cst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .in_ready  (s_axis_tready),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd),
        .status    (status)
    );

    cst_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .init      (init_reg),
        .in_action (s_axis_tuser[0]),
        .in_sent   (s_axis_tdata[31:0]),
        .in_recv   (s_axis_tdata[63:32]),
        .in_seq    (s_axis_tdata[95:64]),
        .in_queue  (s_axis_tdata[111:96]),
        .in_link   (s_axis_tdata[127:112]),
        .send_gap  (send_gap),
        .recv_gap  (recv_gap),
        .slow_gap  (slow_gap),
        .ratio     (ratio),
        .loss      (loss),
        .queue     (queue),
        .link      (link),
        .min_rtt   (min_rtt)
    );

    assign m_axis_tdata = {7'b0, min_rtt, link, queue, loss, ratio, slow_gap,
                           recv_gap, send_gap};

endmodule

[hdl/cst_datapath.sv]
// Datapath: estimator state, EWMA update and shift-subtract RTT ratio divider.
// Depends on cst_pkg.
module cst_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cst_pkg::cmd_t                cmd,
    output cst_pkg::status_t             status,
    input  cst_pkg::init_t               init,
    input  logic                         in_action,
    input  logic [cst_pkg::TICK_BITS-1:0] in_sent,
    input  logic [cst_pkg::TICK_BITS-1:0] in_recv,
    input  logic [cst_pkg::SEQ_W-1:0]    in_seq,
    input  logic [cst_pkg::QUEUE_W-1:0]  in_queue,
    input  logic [cst_pkg::QUEUE_W-1:0]  in_link,
    output logic [cst_pkg::GAP_W-1:0]    send_gap,
    output logic [cst_pkg::GAP_W-1:0]    recv_gap,
    output logic [cst_pkg::GAP_W-1:0]    slow_gap,
    output logic [cst_pkg::GAP_W-1:0]    ratio,
    output logic [cst_pkg::LOSS_W-1:0]   loss,
    output logic [cst_pkg::QUEUE_W-1:0]  queue,
    output logic [cst_pkg::LINK_W-1:0]   link,
    output logic [cst_pkg::TICK_BITS-1:0] min_rtt
);

    localparam int TB = cst_pkg::TICK_BITS;
    localparam int GW = cst_pkg::GAP_W;
    localparam int QW = cst_pkg::FRAC_BITS;

    logic          act_reg;
    logic [TB-1:0] sent_reg, recv_reg;
    logic [cst_pkg::SEQ_W-1:0] seq_reg;
    logic [cst_pkg::QUEUE_W-1:0] qs_reg, ls_reg;

    logic [GW-1:0] send_gap_reg, recv_gap_reg, slow_gap_reg, ratio_reg;
    logic [cst_pkg::LOSS_W-1:0] loss_reg;
    logic [cst_pkg::LINK_W-1:0] link_reg;
    logic [cst_pkg::QUEUE_W-1:0] queue_reg;
    logic [TB-1:0] min_rtt_reg, last_sent_reg, last_recv_reg;
    logic [cst_pkg::SEQ_W-1:0] last_seq_reg;

    logic [TB:0]   rem_reg;
    logic [cst_pkg::CNT_W-1:0] cnt_reg;

    logic [TB-1:0] rtt, min_new, sg_ticks, rg_ticks;
    logic [GW+9:0] sg, rg;
    logic [GW+9:0] send_sum, recv_sum, slow_sum;
    logic [GW+9:0] send_ewma, recv_ewma, slow_ewma;
    logic [cst_pkg::LOSS_W+3:0] loss_sum;
    logic [cst_pkg::LINK_W+3:0] link_sum;
    logic          lossy;
    logic [TB:0]   div_min;

    assign rtt = (recv_reg >= sent_reg) ? recv_reg - sent_reg : '0;
    assign min_new = (rtt < min_rtt_reg) ? rtt : min_rtt_reg;
    assign sg_ticks = (sent_reg - last_sent_reg > cst_pkg::GAP_CLAMP) ? cst_pkg::GAP_CLAMP
                      : sent_reg - last_sent_reg;
    assign rg_ticks = (recv_reg - last_recv_reg > cst_pkg::GAP_CLAMP) ? cst_pkg::GAP_CLAMP
                      : recv_reg - last_recv_reg;
    assign sg = (sent_reg >= last_sent_reg) ? (GW+10)'({sg_ticks[23:0], {QW{1'b0}}})
              : (GW+10)'(send_gap_reg);
    assign rg = (recv_reg > last_recv_reg) ? (GW+10)'({rg_ticks[23:0], {QW{1'b0}}})
              : (GW+10)'(recv_gap_reg);
    assign send_sum = ((GW+10)'(send_gap_reg) << 3) - (GW+10)'(send_gap_reg) + sg;
    assign recv_sum = ((GW+10)'(recv_gap_reg) << 3) - (GW+10)'(recv_gap_reg) + rg;
    assign slow_sum = ((GW+10)'(slow_gap_reg) << 8) - (GW+10)'(slow_gap_reg) + rg;
    assign send_ewma = send_sum >> 3;
    assign recv_ewma = recv_sum >> 3;
    assign slow_ewma = slow_sum >> 8;
    assign lossy = (33'(seq_reg) > 33'(last_seq_reg) + 33'd1);
    assign loss_sum = ((cst_pkg::LOSS_W+4)'(loss_reg) << 3) - (cst_pkg::LOSS_W+4)'(loss_reg)
                      + (lossy ? (cst_pkg::LOSS_W+4)'(cst_pkg::ONE_LOSS) : '0);
    assign link_sum = ((cst_pkg::LINK_W+4)'(link_reg) << 3) - (cst_pkg::LINK_W+4)'(link_reg)
                      + (cst_pkg::LINK_W+4)'({ls_reg, {QW{1'b0}}});
    assign div_min = {1'b0, min_rtt_reg};

    function automatic logic [GW-1:0] sat(input logic [GW+9:0] v);
        return (v > (GW+10)'(cst_pkg::GAP_SAT)) ? cst_pkg::GAP_SAT : v[GW-1:0];
    endfunction

    assign status.restart = act_reg;
    assign status.first = (last_sent_reg == '0) || (last_recv_reg == '0);
    assign status.div_last = (cnt_reg == cst_pkg::CNT_W'(TB + QW - 1));

    // quotient bits of rtt/min over TB integer + QW fraction steps, restoring
    logic [TB+QW-1:0] num_reg;
    logic [TB+QW-1:0] qall_reg;
    logic [TB:0] trial;
    assign trial = {rem_reg[TB-1:0], num_reg[TB+QW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_gap_reg  <= '0;
            recv_gap_reg  <= '0;
            slow_gap_reg  <= '0;
            ratio_reg     <= cst_pkg::ONE_RATIO;
            loss_reg      <= '0;
            link_reg      <= '0;
            queue_reg     <= '0;
            min_rtt_reg   <= '0;
            last_sent_reg <= '0;
            last_recv_reg <= '0;
            last_seq_reg  <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.update)
            begin
                if (act_reg)
                begin
                    send_gap_reg  <= init.send_gap;
                    recv_gap_reg  <= init.recv_gap;
                    slow_gap_reg  <= init.slow_gap;
                    ratio_reg     <= init.ratio;
                    loss_reg      <= init.loss;
                    link_reg      <= init.link;
                    queue_reg     <= init.queue;
                    last_sent_reg <= '0;
                    last_recv_reg <= '0;
                    last_seq_reg  <= '0;
                    min_rtt_reg   <= '0;
                end
                else if (status.first)
                begin
                    last_sent_reg <= sent_reg;
                    last_recv_reg <= recv_reg;
                    min_rtt_reg   <= rtt;
                end
                else
                begin
                    loss_reg <= loss_sum[cst_pkg::LOSS_W+2:3];
                    if (seq_reg > last_seq_reg)
                        last_seq_reg <= seq_reg;
                    send_gap_reg <= sat(send_ewma);
                    recv_gap_reg <= sat(recv_ewma);
                    slow_gap_reg <= sat(slow_ewma);
                    if (sent_reg > last_sent_reg)
                        last_sent_reg <= sent_reg;
                    if (recv_reg > last_recv_reg)
                        last_recv_reg <= recv_reg;
                    min_rtt_reg <= min_new;
                    queue_reg <= qs_reg;
                    link_reg <= link_sum[cst_pkg::LINK_W+2:3];
                end
            end
            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.finish)
            begin
                if (min_rtt_reg == '0 || qall_reg[TB+QW-1:QW] >= cst_pkg::Q_LIMIT)
                    ratio_reg <= cst_pkg::GAP_SAT;
                else
                    ratio_reg <= sat((GW+10)'(qall_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= in_action;
            sent_reg <= in_sent;
            recv_reg <= in_recv;
            seq_reg  <= in_seq;
            qs_reg   <= in_queue;
            ls_reg   <= in_link;
        end
        if (cmd.div_start)
        begin
            num_reg  <= {rtt, {QW{1'b0}}};
            rem_reg  <= '0;
            qall_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (trial >= div_min)
            begin
                rem_reg  <= trial - div_min;
                qall_reg <= {qall_reg[TB+QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial;
                qall_reg <= {qall_reg[TB+QW-2:0], 1'b0};
            end
        end
    end

    assign send_gap = send_gap_reg;
    assign recv_gap = recv_gap_reg;
    assign slow_gap = slow_gap_reg;
    assign ratio    = ratio_reg;
    assign loss     = loss_reg;
    assign queue    = queue_reg;
    assign link     = link_reg;
    assign min_rtt  = min_rtt_reg;

endmodule

[hdl/cst_ctrl.sv]
// Controller: sequences load, update, divider steps and finish, drives the handshakes.
// Depends on cst_pkg.
module cst_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    output logic             in_ready,
    input  logic             out_fire,
    output logic             out_valid,
    output cst_pkg::cmd_t    cmd,
    input  cst_pkg::status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_FINISH,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = in_fire;
        case (state_reg)
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                cmd.div_start = !status.restart && !status.first;
            end
            S_DIV:    cmd.div_step = 1'b1;
            S_FINISH: cmd.finish = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_fire)
                        state_reg <= S_UPDATE;
                S_UPDATE:
                    if (!status.restart && !status.first)
                        state_reg <= S_DIV;
                    else
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                S_DIV:
                    if (status.div_last)
                        state_reg <= S_FINISH;
                S_FINISH:
                begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                    if (out_fire)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
